>>> hdl/phpc_pkg.sv
// phpc_pkg: shared widths, codes, command and result types of the peak hold capture block
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package phpc_pkg;

    // fixed field widths of the channels
    localparam int KIND_W       = 3;
    localparam int FIELD_W      = 16;
    localparam int REST_W       = 64;
    localparam int IDX_FIELD_W  = 8;
    localparam int FILL_FIELD_W = 8;
    localparam int DROP_W       = 32;
    localparam int READ_ACC_W   = 3 * FIELD_W;

    // parameter defaults for the top level
    localparam int DEF_CHUNK_DEPTH   = 256;
    localparam int DEF_ACC_WIDTH     = 16;
    localparam int DEF_PAYLOAD_WIDTH = 64;

    // magnitude arithmetic
    localparam int AXES       = 3;
    localparam int ABS_W      = FIELD_W;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 3'd0,
        KIND_CLEAR   = 3'd1,
        KIND_START   = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_READ    = 3'd4,
        KIND_RELEASE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_MAG,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  exec;
        logic  sq_mul;
        t_axis sq_sel;
        logic  sq_acc;
        logic  root_init;
        logic  root_step;
        logic  mag_commit;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic [FIELD_W-1:0]      peak_x;
        logic [FIELD_W-1:0]      peak_y;
        logic [FIELD_W-1:0]      peak_z;
        logic [FIELD_W-1:0]      magnitude;
        logic                    recording;
        logic                    ready_a;
        logic                    ready_b;
        logic                    active_bank;
        logic [FILL_FIELD_W-1:0] fill_count;
        logic [DROP_W-1:0]       dropped_banks;
        logic [READ_ACC_W-1:0]   read_acc;
        logic [REST_W-1:0]       read_rest;
    } t_result;

endpackage

>>> hdl/phpc_if.sv
// phpc_in_if and phpc_out_if: valid/ready channels for input items and result items
// depends on phpc_pkg for field widths
interface phpc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [phpc_pkg::KIND_W-1:0]          kind;
    logic signed [phpc_pkg::FIELD_W-1:0]  acc_x;
    logic signed [phpc_pkg::FIELD_W-1:0]  acc_y;
    logic signed [phpc_pkg::FIELD_W-1:0]  acc_z;
    logic [phpc_pkg::REST_W-1:0]          sample_rest;
    logic                                 bank_select;
    logic [phpc_pkg::IDX_FIELD_W-1:0]     entry_index;

    modport source (
        output valid, kind, acc_x, acc_y, acc_z, sample_rest, bank_select, entry_index,
        input  ready
    );
    modport sink (
        input  valid, kind, acc_x, acc_y, acc_z, sample_rest, bank_select, entry_index,
        output ready
    );
endinterface

interface phpc_out_if;
    logic                                valid;
    logic                                ready;
    logic [phpc_pkg::FIELD_W-1:0]        peak_x;
    logic [phpc_pkg::FIELD_W-1:0]        peak_y;
    logic [phpc_pkg::FIELD_W-1:0]        peak_z;
    logic [phpc_pkg::FIELD_W-1:0]        magnitude;
    logic                                recording;
    logic                                ready_a;
    logic                                ready_b;
    logic                                active_bank;
    logic [phpc_pkg::FILL_FIELD_W-1:0]   fill_count;
    logic [phpc_pkg::DROP_W-1:0]         dropped_banks;
    logic [phpc_pkg::READ_ACC_W-1:0]     read_acc;
    logic [phpc_pkg::REST_W-1:0]         read_rest;

    modport source (
        output valid, peak_x, peak_y, peak_z, magnitude, recording, ready_a, ready_b,
               active_bank, fill_count, dropped_banks, read_acc, read_rest,
        input  ready
    );
    modport sink (
        input  valid, peak_x, peak_y, peak_z, magnitude, recording, ready_a, ready_b,
               active_bank, fill_count, dropped_banks, read_acc, read_rest,
        output ready
    );
endinterface

>>> hdl/phpc_ctrl.sv
// phpc_ctrl: sequencing state machine, step counter and result valid flag
// depends on phpc_pkg for states, commands and step counts
module phpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  logic            i_is_sample,
    output phpc_pkg::t_cmd  o_cmd
);

    phpc_pkg::t_state             r_state, n_state;
    logic [phpc_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phpc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            phpc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = phpc_pkg::ST_EXEC;
                end
            end
            phpc_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cnt      = '0;
                if (i_is_sample) begin
                    n_state = phpc_pkg::ST_SQUARE;
                end else begin
                    n_state = phpc_pkg::ST_DONE;
                end
            end
            phpc_pkg::ST_SQUARE: begin
                // multiply one axis per step, accumulate the product of the step before
                if (r_cnt < phpc_pkg::CNT_W'(phpc_pkg::AXES)) begin
                    o_cmd.sq_mul = 1'b1;
                    o_cmd.sq_sel = phpc_pkg::t_axis'(r_cnt[1:0]);
                end
                o_cmd.sq_acc = (r_cnt != '0);
                if (r_cnt == phpc_pkg::CNT_W'(phpc_pkg::AXES)) begin
                    n_cnt   = '0;
                    n_state = phpc_pkg::ST_ROOT_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            phpc_pkg::ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = phpc_pkg::ST_ROOT;
            end
            phpc_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == phpc_pkg::CNT_W'(phpc_pkg::ROOT_STEPS - 1)) begin
                    n_state = phpc_pkg::ST_MAG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            phpc_pkg::ST_MAG: begin
                o_cmd.mag_commit = 1'b1;
                n_state          = phpc_pkg::ST_DONE;
            end
            phpc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = phpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = phpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/phpc_datapath.sv
// phpc_datapath: item registers, peak holds, bank bookkeeping, sample store,
// shared squaring multiplier, bit-serial square root and result register
// depends on phpc_pkg; driven by phpc_ctrl commands
module phpc_datapath #(
    parameter int CHUNK_DEPTH   = phpc_pkg::DEF_CHUNK_DEPTH,
    parameter int ACC_WIDTH     = phpc_pkg::DEF_ACC_WIDTH,
    parameter int PAYLOAD_WIDTH = phpc_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  phpc_pkg::t_cmd                        i_cmd,
    input  logic [phpc_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [phpc_pkg::FIELD_W-1:0]   i_acc_x,
    input  logic signed [phpc_pkg::FIELD_W-1:0]   i_acc_y,
    input  logic signed [phpc_pkg::FIELD_W-1:0]   i_acc_z,
    input  logic [phpc_pkg::REST_W-1:0]           i_sample_rest,
    input  logic                                  i_bank_select,
    input  logic [phpc_pkg::IDX_FIELD_W-1:0]      i_entry_index,
    output logic                                  o_is_sample,
    output phpc_pkg::t_result                     o_result
);

    localparam int STORE_DEPTH = 2 * CHUNK_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(CHUNK_DEPTH);
    localparam int FC_W        = (FILL_W > phpc_pkg::FILL_FIELD_W) ? FILL_W
                                                                   : phpc_pkg::FILL_FIELD_W;
    localparam int IDX_W       = (ADDR_W > phpc_pkg::IDX_FIELD_W) ? ADDR_W
                                                                  : phpc_pkg::IDX_FIELD_W;
    localparam int WORD_W      = phpc_pkg::READ_ACC_W + PAYLOAD_WIDTH;
    localparam int FW          = phpc_pkg::FIELD_W;
    localparam int SIGN_W      = (ACC_WIDTH < FW) ? ACC_WIDTH : FW;
    localparam bit IS_SIGNED   = (ACC_WIDTH <= FW);
    localparam logic [FW:0]   SPAN = (FW+1)'(1) << SIGN_W;
    localparam logic [FW-1:0] MASK = FW'(SPAN - (FW+1)'(1));

    localparam int ABS_W  = phpc_pkg::ABS_W;
    localparam int SQ_W   = phpc_pkg::SQ_W;
    localparam int SUM_W  = phpc_pkg::SUM_W;
    localparam int ROOT_W = phpc_pkg::ROOT_W;
    localparam int REM_W  = phpc_pkg::REM_W;

    // absolute value of the low SIGN_W bits, sign taken at the top of that range when IS_SIGNED
    function automatic logic [ABS_W-1:0] abs_val(input logic [FW-1:0] raw);
        logic [FW:0] m;
        logic        neg;
        m       = (FW+1)'(raw & MASK);
        neg     = IS_SIGNED && raw[SIGN_W-1];
        abs_val = neg ? ABS_W'(SPAN - m) : m[ABS_W-1:0];
    endfunction

    // latched item
    logic [phpc_pkg::KIND_W-1:0]      r_kind;
    logic [FW-1:0]                    r_x, r_y, r_z;
    logic [PAYLOAD_WIDTH-1:0]         r_rest;
    logic                             r_sel_bank;
    logic [phpc_pkg::IDX_FIELD_W-1:0] r_idx;

    // block state
    logic [ABS_W-1:0]            r_peak_x, r_peak_y, r_peak_z;
    logic [ABS_W-1:0]            n_peak_x, n_peak_y, n_peak_z;
    logic [FW-1:0]               r_mag;
    logic                        r_rec, n_rec;
    logic                        r_fbank, n_fbank;
    logic                        r_rdy_a, n_rdy_a;
    logic                        r_rdy_b, n_rdy_b;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic [phpc_pkg::DROP_W-1:0] r_drop, n_drop;
    logic [FILL_W-1:0]           r_shown, n_shown;
    logic                        r_hit, n_hit;

    // store
    logic [WORD_W-1:0] mem [STORE_DEPTH];
    logic [WORD_W-1:0] r_rd_word;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_slot, rd_slot;
    logic [IDX_W-1:0]  idx_wide;

    // magnitude
    logic [ABS_W-1:0]  abs_x, abs_y, abs_z, mul_op;
    logic [SQ_W-1:0]   r_prod;
    logic [SUM_W-1:0]  r_sum, r_src;
    logic [REM_W-1:0]  r_rem, rem_pre, trial;
    logic [ROOT_W-1:0] r_root;

    phpc_pkg::t_result r_res;
    logic [FC_W-1:0]   fc_wide;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_x        <= i_acc_x;
            r_y        <= i_acc_y;
            r_z        <= i_acc_z;
            r_rest     <= i_sample_rest[PAYLOAD_WIDTH-1:0];
            r_sel_bank <= i_bank_select;
            r_idx      <= i_entry_index;
        end
    end

    assign o_is_sample = (r_kind == phpc_pkg::KIND_SAMPLE);

    assign abs_x = abs_val(r_x);
    assign abs_y = abs_val(r_y);
    assign abs_z = abs_val(r_z);

    assign idx_wide = IDX_W'(r_idx);
    assign wr_slot  = ADDR_W'(r_fill) + (r_fbank ? ADDR_W'(CHUNK_DEPTH) : '0);
    assign rd_slot  = ADDR_W'(idx_wide) + (r_sel_bank ? ADDR_W'(CHUNK_DEPTH) : '0);

    // per-kind bookkeeping, committed in the execute cycle
    always_comb begin
        n_peak_x = r_peak_x;
        n_peak_y = r_peak_y;
        n_peak_z = r_peak_z;
        n_rec    = r_rec;
        n_fbank  = r_fbank;
        n_rdy_a  = r_rdy_a;
        n_rdy_b  = r_rdy_b;
        n_fill   = r_fill;
        n_drop   = r_drop;
        n_hit    = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        unique case (r_kind)
            phpc_pkg::KIND_SAMPLE: begin
                if (abs_x > r_peak_x) n_peak_x = abs_x;
                if (abs_y > r_peak_y) n_peak_y = abs_y;
                if (abs_z > r_peak_z) n_peak_z = abs_z;
                if (r_rec) begin
                    wr_en = 1'b1;
                    if (r_fill == FILL_W'(CHUNK_DEPTH - 1)) begin
                        // bank full: mark it, count a drop if it was never released
                        if (r_fbank) begin
                            if (r_rdy_b && (r_drop != '1)) n_drop = r_drop + 1'b1;
                            n_rdy_b = 1'b1;
                        end else begin
                            if (r_rdy_a && (r_drop != '1)) n_drop = r_drop + 1'b1;
                            n_rdy_a = 1'b1;
                        end
                        n_fbank = ~r_fbank;
                        n_fill  = '0;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            phpc_pkg::KIND_CLEAR: begin
                n_peak_x = '0;
                n_peak_y = '0;
                n_peak_z = '0;
            end
            phpc_pkg::KIND_START: begin
                if (!r_rec) begin
                    n_drop  = '0;
                    n_fill  = '0;
                    n_fbank = 1'b0;
                    n_rdy_a = 1'b0;
                    n_rdy_b = 1'b0;
                    n_rec   = 1'b1;
                end
            end
            phpc_pkg::KIND_STOP: begin
                if (r_rec) begin
                    n_rec   = 1'b0;
                    n_fill  = '0;
                    n_rdy_a = 1'b0;
                    n_rdy_b = 1'b0;
                end
            end
            phpc_pkg::KIND_READ: begin
                if (idx_wide < IDX_W'(CHUNK_DEPTH)) begin
                    rd_en = 1'b1;
                    n_hit = 1'b1;
                end
            end
            phpc_pkg::KIND_RELEASE: begin
                if (r_sel_bank) begin
                    n_rdy_b = 1'b0;
                end else begin
                    n_rdy_a = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // a stop shows the count from before clearing
        n_shown = (r_kind == phpc_pkg::KIND_STOP) ? r_fill : n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_x <= '0;
            r_peak_y <= '0;
            r_peak_z <= '0;
            r_rec    <= 1'b0;
            r_fbank  <= 1'b0;
            r_rdy_a  <= 1'b0;
            r_rdy_b  <= 1'b0;
            r_fill   <= '0;
            r_drop   <= '0;
        end else if (i_cmd.exec) begin
            r_peak_x <= n_peak_x;
            r_peak_y <= n_peak_y;
            r_peak_z <= n_peak_z;
            r_rec    <= n_rec;
            r_fbank  <= n_fbank;
            r_rdy_a  <= n_rdy_a;
            r_rdy_b  <= n_rdy_b;
            r_fill   <= n_fill;
            r_drop   <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_shown <= n_shown;
            r_hit   <= n_hit;
        end
    end

    // single-port store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_slot] <= {r_x, r_y, r_z, r_rest};
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_word <= mem[rd_slot];
        end
    end

    // one shared multiplier, one axis a step
    always_comb begin
        case (i_cmd.sq_sel)
            phpc_pkg::AXIS_Y: mul_op = abs_y;
            phpc_pkg::AXIS_Z: mul_op = abs_z;
            default:          mul_op = abs_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) begin
            r_prod <= SQ_W'(mul_op) * SQ_W'(mul_op);
        end
        priority if (i_cmd.exec) begin
            r_sum <= '0;
        end else if (i_cmd.sq_acc) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
    end

    // restoring square root, one root bit a step
    assign rem_pre = {r_rem[REM_W-3:0], r_src[SUM_W-1 -: 2]};
    assign trial   = REM_W'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.root_init) begin
            r_src  <= r_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_src <= r_src << 2;
            if (rem_pre >= trial) begin
                r_rem  <= rem_pre - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_pre;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else if (i_cmd.mag_commit) begin
            r_mag <= r_root[ROOT_W-1] ? '1 : r_root[FW-1:0];
        end
    end

    assign fc_wide = FC_W'(r_shown);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res.peak_x        <= r_peak_x;
            r_res.peak_y        <= r_peak_y;
            r_res.peak_z        <= r_peak_z;
            r_res.magnitude     <= r_mag;
            r_res.recording     <= r_rec;
            r_res.ready_a       <= r_rdy_a;
            r_res.ready_b       <= r_rdy_b;
            r_res.active_bank   <= r_fbank;
            r_res.fill_count    <= fc_wide[phpc_pkg::FILL_FIELD_W-1:0];
            r_res.dropped_banks <= r_drop;
            r_res.read_acc      <= r_hit ? r_rd_word[WORD_W-1 -: phpc_pkg::READ_ACC_W] : '0;
            r_res.read_rest     <= r_hit ? phpc_pkg::REST_W'(r_rd_word[PAYLOAD_WIDTH-1:0])
                                         : '0;
        end
    end

    assign o_result = r_res;

endmodule

>>> hdl/peak_hold_pingpong_capture.sv
// peak_hold_pingpong_capture: top level, joins controller and datapath to the channels
// depends on phpc_pkg, phpc_if, phpc_ctrl and phpc_datapath

// One input transaction gives exactly one result transaction, showing the status after
// that item. A sample raises the per-axis peak holds, computes the floor root of
// x*x+y*y+z*z and, while recording, appends the sample to the active bank of a two-bank
// store; a full bank is flagged ready and filling moves to the other bank, with a
// saturating drop count when the full bank was never released. Items are handled one
// at a time: a sample goes through execute, four steps of the shared squaring
// multiplier, then 17 steps of the one-bit-a-step square root before the next item
// can be taken, and every other kind goes only through execute. The input is taken
// again while a finished result still waits in the output register; a second result
// waits only when the first has not been taken. Reads return the entry written at that
// place of the selected bank; an entry never written reads undefined data, and an index
// at or above CHUNK_DEPTH reads as zero. The store is not cleared after reset.
module peak_hold_pingpong_capture #(
    parameter int CHUNK_DEPTH   = phpc_pkg::DEF_CHUNK_DEPTH,
    parameter int ACC_WIDTH     = phpc_pkg::DEF_ACC_WIDTH,
    parameter int PAYLOAD_WIDTH = phpc_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phpc_in_if.sink     i_in,
    phpc_out_if.source  o_out
);

    phpc_pkg::t_cmd    cmd;
    phpc_pkg::t_result res;
    logic              in_ready;
    logic              out_valid;
    logic              is_sample;

    // sequencing
    phpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_is_sample (is_sample),
        .o_cmd       (cmd)
    );

    // state, store and arithmetic
    phpc_datapath #(
        .CHUNK_DEPTH   (CHUNK_DEPTH),
        .ACC_WIDTH     (ACC_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_in.kind),
        .i_acc_x       (i_in.acc_x),
        .i_acc_y       (i_in.acc_y),
        .i_acc_z       (i_in.acc_z),
        .i_sample_rest (i_in.sample_rest),
        .i_bank_select (i_in.bank_select),
        .i_entry_index (i_in.entry_index),
        .o_is_sample   (is_sample),
        .o_result      (res)
    );

    // channel wiring
    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.peak_x        = res.peak_x;
    assign o_out.peak_y        = res.peak_y;
    assign o_out.peak_z        = res.peak_z;
    assign o_out.magnitude     = res.magnitude;
    assign o_out.recording     = res.recording;
    assign o_out.ready_a       = res.ready_a;
    assign o_out.ready_b       = res.ready_b;
    assign o_out.active_bank   = res.active_bank;
    assign o_out.fill_count    = res.fill_count;
    assign o_out.dropped_banks = res.dropped_banks;
    assign o_out.read_acc      = res.read_acc;
    assign o_out.read_rest     = res.read_rest;

    // an accepted transaction is executed in the very next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> cmd.exec)
        else $error("accepted transaction not executed next cycle");

    // the result register is never overwritten while a result is still pending
    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before it was taken");

    // magnitude is committed only right after the last root step
    a_mag_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mag_commit |-> $past(cmd.root_step))
        else $error("magnitude committed without a finished root");

endmodule
